// ===== hdl/assert_macros.svh =====
// assertion macros shared by the codec modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the cycle after the antecedent, off during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// consequent checked in the same cycle as the antecedent, off during reset
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== hdl/mdc_pkg.sv =====
// shared types and constants of the multichannel delta codec
package mdc_pkg;

	localparam int MAX_CHANNELS = 64;
	localparam int CH_W         = $clog2(MAX_CHANNELS);
	localparam int SAMPLE_W     = 16;
	localparam int NUM_CH_W     = 7;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = NUM_CH_W;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_MODE         = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_CHANNELS = 1'b1;

	// mode register codes
	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                last_in_stream;
	} in_item_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] result;
		logic                last_out;
	} out_item_t;

	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic            first_row;
	} chan_info_t;

endpackage

// ===== hdl/mdc_ram.sv =====
// generic single-write, single-read memory with registered read and write bypass
module mdc_ram #(
	parameter int DEPTH  = 64,
	parameter int WIDTH  = 16,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// same-edge write to the read address returns the new data
		if (re) begin
			rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
		end
	end

endmodule

// ===== hdl/mdc_chan_seq.sv =====
// channel counter and first-row tracking for the sample stream
`include "assert_macros.svh"

module mdc_chan_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  logic                         last,
	input  logic [mdc_pkg::NUM_CH_W-1:0] num_channels,
	output mdc_pkg::chan_info_t          info
);

	logic [mdc_pkg::CH_W-1:0] ch_q;
	logic                     first_q;
	logic [mdc_pkg::CH_W-1:0] last_ch;
	logic [mdc_pkg::CH_W-1:0] ch_eff;
	logic                     row_end;

	// highest channel of a row, count clamped to 1..MAX_CHANNELS
	always_comb begin
		if (num_channels == '0) begin
			last_ch = '0;
		end else if (num_channels > mdc_pkg::NUM_CH_W'(mdc_pkg::MAX_CHANNELS)) begin
			last_ch = mdc_pkg::CH_W'(mdc_pkg::MAX_CHANNELS - 1);
		end else begin
			last_ch = mdc_pkg::CH_W'(num_channels - mdc_pkg::NUM_CH_W'(1));
		end
	end

	assign row_end        = (ch_q >= last_ch);
	assign ch_eff         = (ch_q > last_ch) ? last_ch : ch_q;
	assign info.ch        = ch_eff;
	assign info.first_row = first_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q    <= '0;
			first_q <= 1'b1;
		end else if (advance) begin
			if (last) begin
				ch_q    <= '0;
				first_q <= 1'b1;
			end else if (row_end) begin
				ch_q    <= '0;
				first_q <= 1'b0;
			end else begin
				ch_q <= ch_eff + mdc_pkg::CH_W'(1);
			end
		end
	end

	`ASSERT_NEXT(a_last_restarts, advance && last, (ch_q == '0) && first_q, "stream end did not restart the row")
	`ASSERT_NEXT(a_row_wraps, advance && !last && row_end, (ch_q == '0) && !first_q, "row end did not wrap to channel zero")

endmodule

// ===== hdl/multichannel_delta_codec.sv =====
// top level of the multichannel delta codec: config, input stage, store and result register
//
// channel | handshake          | payload
// --------+--------------------+----------------------------------
// cfg     | cfg_we             | cfg_index, cfg_wdata
// in      | in_valid/in_ready  | in_data.sample, in_data.last_in_stream
// out     | out_valid/out_ready| out_data.result, out_data.last_out
//
// one sample per cycle sustained unless the result register stalls; a sample is held
// in the input stage with its previous-row read; the add/subtract is then registered.
// the previous-row store is one 64-entry memory, read on accept and written as the input
// stage moves on; a same-channel read at that edge takes the bypassed write data.
// reset clears counter and valids, sets first-row flag and config; store holds no reset.
// a stalled result register holds the input stage, which then holds in_ready low.
`include "assert_macros.svh"

module multichannel_delta_codec (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mdc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mdc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  mdc_pkg::in_item_t              in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output mdc_pkg::out_item_t             out_data
);

	logic                         mode_q;
	logic [mdc_pkg::NUM_CH_W-1:0] num_channels_q;

	logic                         valid_s1;
	logic [mdc_pkg::SAMPLE_W-1:0] sample_s1;
	logic                         last_s1;
	logic [mdc_pkg::CH_W-1:0]     ch_s1;
	logic                         first_s1;

	logic                         out_valid_q;
	mdc_pkg::out_item_t           out_data_q;

	mdc_pkg::chan_info_t          chan;
	logic                         accept;
	logic                         out_free;
	logic                         s1_adv;
	logic [mdc_pkg::SAMPLE_W-1:0] rd_data;
	logic [mdc_pkg::SAMPLE_W-1:0] prev;
	logic [mdc_pkg::SAMPLE_W-1:0] result;
	logic [mdc_pkg::SAMPLE_W-1:0] wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= mdc_pkg::MODE_ENCODE;
			num_channels_q <= mdc_pkg::NUM_CH_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				mdc_pkg::REG_MODE: begin
					mode_q <= cfg_wdata[0];
				end
				mdc_pkg::REG_NUM_CHANNELS: begin
					num_channels_q <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign s1_adv   = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;
	assign accept   = in_valid && in_ready;

	mdc_chan_seq u_chan_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (accept),
		.last         (in_data.last_in_stream),
		.num_channels (num_channels_q),
		.info         (chan)
	);

	mdc_ram #(
		.DEPTH (mdc_pkg::MAX_CHANNELS),
		.WIDTH (mdc_pkg::SAMPLE_W)
	) u_prev_row (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (ch_s1),
		.wdata (wdata),
		.re    (accept),
		.raddr (chan.ch),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= in_data.sample;
			last_s1   <= in_data.last_in_stream;
			ch_s1     <= chan.ch;
			first_s1  <= chan.first_row;
		end
	end

	// first row pairs with zero; the store always keeps reconstructed values
	assign prev   = first_s1 ? '0 : rd_data;
	assign result = (mode_q == mdc_pkg::MODE_DECODE) ? (sample_s1 + prev) : (sample_s1 - prev);
	assign wdata  = (mode_q == mdc_pkg::MODE_DECODE) ? result : sample_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_data_q.result   <= result;
			out_data_q.last_out <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`ASSERT_NEXT(a_stall_holds_read, valid_s1 && !out_free, $stable(rd_data), "store read changed under a stalled transaction")
	`ASSERT_NEXT(a_s1_to_out, s1_adv, out_valid_q, "input stage moved on without loading a result")
	`ASSERT_NEXT(a_bypass, s1_adv && accept && (chan.ch == ch_s1), rd_data == $past(wdata), "same-channel read missed the bypassed write")

endmodule

// ===== tb/multichannel_delta_codec_tb.sv =====
// self-checking testbench of the multichannel delta codec with its own behavioral predictor
module multichannel_delta_codec_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SEGMENTS    = 6;
	localparam int SEG_ITEMS   = 50;

	typedef struct {
		bit                             is_cfg;
		logic [mdc_pkg::CFG_IDX_W-1:0]  idx;
		logic [mdc_pkg::CFG_DATA_W-1:0] wdata;
		mdc_pkg::in_item_t              item;
		bit                             typed;
		logic [mdc_pkg::SAMPLE_W-1:0]   want;
	} dir_row_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [mdc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [mdc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	mdc_pkg::in_item_t              in_data = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	mdc_pkg::out_item_t             out_data;

	// predictor state
	logic                             p_mode = mdc_pkg::MODE_ENCODE;
	logic [mdc_pkg::NUM_CH_W-1:0]     p_nch = 7'd1;
	logic [mdc_pkg::SAMPLE_W-1:0]     p_row [mdc_pkg::MAX_CHANNELS];
	int                               p_ch = 0;
	bit                               p_first = 1'b1;
	bit [mdc_pkg::MAX_CHANNELS-1:0]   p_written = '0;

	mdc_pkg::out_item_t coded_values [$];
	dir_row_t           dir_tab [$];
	int                 err_count = 0;
	int                 cycle_count = 0;
	int                 rx_count = 0;
	int                 send_idle_pct = 25;
	int                 recv_idle_pct = 84;
	int                 hold_left = 0;
	bit                 hold_done = 1'b0;
	int                 stream_left = 0;

	multichannel_delta_codec dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int eff_channels(logic [mdc_pkg::NUM_CH_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > mdc_pkg::MAX_CHANNELS)
			return mdc_pkg::MAX_CHANNELS;
		return int'(v);
	endfunction

	// one sample through the codec: difference or running sum against the previous row
	function automatic mdc_pkg::out_item_t apply_codec(mdc_pkg::in_item_t it);
		int                           n;
		int                           c;
		bit                           row_end;
		logic [mdc_pkg::SAMPLE_W-1:0] prev;
		mdc_pkg::out_item_t           o;
		n = eff_channels(p_nch);
		c = p_ch;
		if (c >= n) begin
			c = n - 1;
			row_end = 1'b1;
		end else begin
			row_end = (c + 1 >= n);
		end
		prev = p_first ? '0 : p_row[c];
		if (p_mode == mdc_pkg::MODE_ENCODE) begin
			o.result = it.sample - prev;
			p_row[c] = it.sample;
		end else begin
			o.result = it.sample + prev;
			p_row[c] = o.result;
		end
		p_written[c] = 1'b1;
		o.last_out = it.last_in_stream;
		if (it.last_in_stream) begin
			p_ch = 0;
			p_first = 1'b1;
		end else if (row_end) begin
			p_ch = 0;
			p_first = 1'b0;
		end else begin
			p_ch = c + 1;
		end
		return o;
	endfunction

	function automatic dir_row_t cfg_row(logic [mdc_pkg::CFG_IDX_W-1:0] idx, int val);
		dir_row_t r;
		r = '{is_cfg: 1'b1, idx: idx, wdata: val[mdc_pkg::CFG_DATA_W-1:0], item: '0,
			typed: 1'b0, want: '0};
		return r;
	endfunction

	function automatic dir_row_t item_row(int smp, bit last, bit typed, int want);
		dir_row_t r;
		r = '{is_cfg: 1'b0, idx: '0, wdata: '0, item: '{smp[mdc_pkg::SAMPLE_W-1:0], last},
			typed: typed, want: want[mdc_pkg::SAMPLE_W-1:0]};
		return r;
	endfunction

	function automatic logic [mdc_pkg::SAMPLE_W-1:0] rand_sample();
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 3))
				0: return 16'h0000;
				1: return 16'hFFFF;
				2: return 16'h8000;
				default: return 16'h7FFF;
			endcase
		end
		return mdc_pkg::SAMPLE_W'($urandom_range(0, 65535));
	endfunction

	// a higher channel count mid-stream is only safe when the rows it reaches were written
	function automatic int pick_channels();
		int r;
		int v;
		int n;
		r = $urandom_range(0, 99);
		if (r < 50)
			v = $urandom_range(1, 8);
		else if (r < 65)
			v = $urandom_range(9, 63);
		else if (r < 75)
			v = mdc_pkg::MAX_CHANNELS;
		else if (r < 82)
			v = 0;
		else if (r < 90)
			v = $urandom_range(65, 126);
		else
			v = 127;
		n = eff_channels(v[mdc_pkg::NUM_CH_W-1:0]);
		if (!p_first && n > eff_channels(p_nch)) begin
			for (int i = 0; i < n; i++) begin
				if (!p_written[i])
					return int'(p_nch);
			end
		end
		return v;
	endfunction

	task automatic write_reg(logic [mdc_pkg::CFG_IDX_W-1:0] idx,
		logic [mdc_pkg::CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == mdc_pkg::REG_MODE)
			p_mode = val[0];
		else
			p_nch = val;
	endtask

	// returns at the edge where the transaction is taken
	task automatic send_sample(mdc_pkg::in_item_t it, bit typed,
		logic [mdc_pkg::SAMPLE_W-1:0] want);
		mdc_pkg::out_item_t o;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do
			@(posedge clk);
		while (!in_ready);
		o = apply_codec(it);
		if (typed)
			o.result = want;
		coded_values.push_back(o);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (coded_values.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// mostly whole rows closed by a last mark, sometimes a stream cut at a random point
	task automatic send_stream_item();
		int                n;
		mdc_pkg::in_item_t it;
		if (stream_left == 0) begin
			n = eff_channels(p_nch);
			if ($urandom_range(0, 99) < 80)
				stream_left = n * $urandom_range(1, (n > 16) ? 2 : 6);
			else
				stream_left = $urandom_range(1, 3 * n);
		end
		it.sample = rand_sample();
		it.last_in_stream = (stream_left == 1);
		stream_left--;
		send_sample(it, 1'b0, '0);
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin : rx_side
		mdc_pkg::out_item_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				rx_count++;
				if (coded_values.size() == 0) begin
					$error("result %h last %b with no transaction outstanding",
						out_data.result, out_data.last_out);
					err_count++;
				end else begin
					want = coded_values.pop_front();
					if (out_data.result !== want.result) begin
						$error("result: expected %h, got %h", want.result, out_data.result);
						err_count++;
					end
					if (out_data.last_out !== want.last_out) begin
						$error("last_out: expected %b, got %b", want.last_out,
							out_data.last_out);
						err_count++;
					end
				end
			end
			// one long back-pressure stretch so the pipeline fills and in_ready drops
			if (!hold_done && rx_count >= 150) begin
				hold_done <= 1'b1;
				hold_left <= 300;
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		for (int i = 0; i < mdc_pkg::MAX_CHANNELS; i++)
			p_row[i] = '0;

		// first row passes through, later rows wrap modulo 2^16
		dir_tab.push_back(item_row(16'h1234, 0, 1, 16'h1234));
		dir_tab.push_back(item_row(16'h1000, 0, 0, 0));
		dir_tab.push_back(item_row(16'h0000, 0, 0, 0));
		dir_tab.push_back(item_row(16'hFFFF, 1, 0, 0));
		// zero channels acts as one
		dir_tab.push_back(cfg_row(mdc_pkg::REG_NUM_CHANNELS, 0));
		dir_tab.push_back(item_row(16'hFFFF, 0, 1, 16'hFFFF));
		dir_tab.push_back(item_row(16'h0001, 1, 0, 0));
		// above the maximum saturates
		dir_tab.push_back(cfg_row(mdc_pkg::REG_NUM_CHANNELS, 127));
		dir_tab.push_back(item_row(16'h8000, 0, 1, 16'h8000));
		dir_tab.push_back(item_row(16'h7FFF, 1, 1, 16'h7FFF));
		dir_tab.push_back(cfg_row(mdc_pkg::REG_NUM_CHANNELS, 3));
		dir_tab.push_back(item_row(16'h0003, 0, 1, 16'h0003));
		dir_tab.push_back(item_row(16'h0002, 0, 1, 16'h0002));
		dir_tab.push_back(item_row(16'h0001, 0, 1, 16'h0001));
		dir_tab.push_back(item_row(16'h0010, 0, 0, 0));
		dir_tab.push_back(item_row(16'h0020, 0, 0, 0));
		// count lowered under the channel index: next sample closes the row
		dir_tab.push_back(cfg_row(mdc_pkg::REG_NUM_CHANNELS, 2));
		dir_tab.push_back(item_row(16'h0030, 0, 0, 0));
		dir_tab.push_back(item_row(16'h0040, 0, 0, 0));
		// mode switched inside a stream
		dir_tab.push_back(cfg_row(mdc_pkg::REG_MODE, int'(mdc_pkg::MODE_DECODE)));
		dir_tab.push_back(item_row(16'hFFFF, 0, 0, 0));
		dir_tab.push_back(item_row(16'h0001, 1, 0, 0));
		dir_tab.push_back(cfg_row(mdc_pkg::REG_NUM_CHANNELS, mdc_pkg::MAX_CHANNELS));
		dir_tab.push_back(item_row(16'h0000, 0, 1, 16'h0000));
		dir_tab.push_back(item_row(16'hFFFF, 0, 1, 16'hFFFF));
		dir_tab.push_back(item_row(16'h8000, 1, 1, 16'h8000));
		dir_tab.push_back(cfg_row(mdc_pkg::REG_MODE, int'(mdc_pkg::MODE_ENCODE)));
		dir_tab.push_back(cfg_row(mdc_pkg::REG_NUM_CHANNELS, 1));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg) begin
				wait_idle();
				write_reg(dir_tab[i].idx, dir_tab[i].wdata);
			end else begin
				send_sample(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);
			end
		end

		// streams stay open across segments, so config changes also land mid-stream
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 25;
					recv_idle_pct = 84;
				end
				1: begin
					send_idle_pct = 84;
					recv_idle_pct = 25;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int s = 0; s < SEGMENTS; s++) begin
				wait_idle();
				if ($urandom_range(0, 1))
					write_reg(mdc_pkg::REG_MODE, mdc_pkg::CFG_DATA_W'($urandom_range(0, 1) ?
						mdc_pkg::MODE_DECODE : mdc_pkg::MODE_ENCODE));
				if ($urandom_range(0, 9) < 7)
					write_reg(mdc_pkg::REG_NUM_CHANNELS,
						mdc_pkg::CFG_DATA_W'(pick_channels()));
				repeat (SEG_ITEMS) send_stream_item();
			end
		end

		wait_idle();
		repeat (5) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
